>>> rtl/button_tap_hold_tracker_defines.svh
// Assertion macros shared by the button tap/hold tracker RTL.
`ifndef BUTTON_TAP_HOLD_TRACKER_DEFINES_SVH
`define BUTTON_TAP_HOLD_TRACKER_DEFINES_SVH

`ifndef ASSERT_OFF

// same-cycle implication, disabled while in reset
`define BTHT_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed: %m");

// next-cycle implication, disabled while in reset
`define BTHT_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed: %m");

`else

`define BTHT_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define BTHT_ASSERT_NXT(lbl, clk, rstn, ante, cons)

`endif

`endif

>>> rtl/btht_pkg.sv
// Types and constants shared by the button tap/hold tracker.
`default_nettype none

package btht_pkg;

    localparam int BUTTONS_DEF   = 16;
    localparam int TIME_BITS_DEF = 32;
    localparam int WIDE_BITS     = 64;   // widest supported tick counter
    localparam int MASK_BITS     = 16;   // buttons visible on the ports
    localparam int NOW_BITS      = 32;
    localparam int BTN_BITS      = 4;
    localparam int THR_BITS      = 32;
    localparam int SINCE_BITS    = 32;
    localparam int ACT_BITS      = 2;
    localparam int S_DATA_BITS   = 56;
    localparam int M_DATA_BITS   = 120;
    localparam logic [THR_BITS-1:0] THR_RESET = 32'd500;

    typedef enum logic [ACT_BITS-1:0] {
        ACT_POLL   = 2'd0,
        ACT_IGNORE = 2'd1,
        ACT_MARK   = 2'd2,
        ACT_QUERY  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_TAP  = 2'd1,
        KIND_HOLD = 2'd2
    } kind_t;

    typedef struct packed {
        action_t              action;
        logic                 connected;
        logic [BTN_BITS-1:0]  button;
    } lane_cmd_t;

    // per-button status after the word is applied
    typedef struct packed {
        logic down;
        logic down_any;
        logic tap;
        logic hold;
        logic processed;
    } lane_stat_t;

endpackage

`default_nettype wire

>>> rtl/btht_lane.sv
// One button's press tracker: state registers and tap/hold classification.
`default_nettype none
`include "button_tap_hold_tracker_defines.svh"

module btht_lane #(
    parameter int TIME_BITS = btht_pkg::TIME_BITS_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           in_fire,
    input  wire btht_pkg::lane_cmd_t            cmd,
    input  wire logic [TIME_BITS-1:0]           now,
    input  wire logic                           held,
    input  wire logic                           sel,
    input  wire logic [btht_pkg::THR_BITS-1:0]  threshold,
    output btht_pkg::lane_stat_t                stat,
    output logic [TIME_BITS-1:0]                since
);

    localparam int CMP_W = (TIME_BITS > btht_pkg::THR_BITS) ? TIME_BITS : btht_pkg::THR_BITS;

    logic [TIME_BITS-1:0] press_start_reg, press_start_next;
    logic                 pressed_reg, pressed_next;
    logic                 ignored_reg, ignored_next;
    logic                 processed_reg, processed_next;
    btht_pkg::kind_t      kind_reg, kind_next;

    logic [TIME_BITS-1:0] elapsed;
    logic                 is_hold;

    assign elapsed = now - press_start_reg;   // wraps modulo 2^TIME_BITS
    assign is_hold = CMP_W'(elapsed) >= CMP_W'(threshold);

    always_comb begin
        press_start_next = press_start_reg;
        pressed_next     = pressed_reg;
        ignored_next     = ignored_reg;
        processed_next   = processed_reg;
        kind_next        = kind_reg;
        case (cmd.action)
            btht_pkg::ACT_POLL: begin
                processed_next = 1'b0;
                if (!cmd.connected) begin
                    kind_next = btht_pkg::KIND_NONE;
                end else if (!pressed_reg) begin
                    kind_next = btht_pkg::KIND_NONE;
                    if (held) begin
                        press_start_next = now;
                        pressed_next     = 1'b1;
                    end
                end else if (!held) begin
                    ignored_next     = 1'b0;
                    pressed_next     = 1'b0;
                    press_start_next = '0;
                    kind_next        = is_hold ? btht_pkg::KIND_HOLD : btht_pkg::KIND_TAP;
                end
            end
            btht_pkg::ACT_IGNORE: begin
                if (pressed_reg) begin
                    ignored_next = 1'b1;
                end
            end
            btht_pkg::ACT_MARK: begin
                if (sel) begin
                    processed_next = 1'b1;
                end
            end
            btht_pkg::ACT_QUERY: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            press_start_reg <= '0;
            pressed_reg     <= 1'b0;
            ignored_reg     <= 1'b0;
            processed_reg   <= 1'b0;
            kind_reg        <= btht_pkg::KIND_NONE;
        end else if (in_fire) begin
            press_start_reg <= press_start_next;
            pressed_reg     <= pressed_next;
            ignored_reg     <= ignored_next;
            processed_reg   <= processed_next;
            kind_reg        <= kind_next;
        end
    end

    always_comb begin
        stat.down_any  = pressed_next;
        stat.down      = pressed_next & ~ignored_next;
        stat.tap       = (kind_next == btht_pkg::KIND_TAP);
        stat.hold      = (kind_next == btht_pkg::KIND_HOLD);
        stat.processed = processed_next;
    end

    // query leaves state untouched, so the current press time is the answer
    assign since = (cmd.action == btht_pkg::ACT_QUERY && sel && pressed_reg)
                   ? press_start_reg : '0;

    `BTHT_ASSERT_IMP(a_down_no_kind, aclk, aresetn, pressed_reg, kind_reg == btht_pkg::KIND_NONE)
    `BTHT_ASSERT_IMP(a_up_zero_start, aclk, aresetn, !pressed_reg, press_start_reg == '0)
    `BTHT_ASSERT_IMP(a_ignore_needs_down, aclk, aresetn, ignored_reg, pressed_reg)

endmodule

`default_nettype wire

>>> rtl/btht_merge.sv
// Merges lane status into result masks and buffers results in a two-entry skid.
`default_nettype none
`include "button_tap_hold_tracker_defines.svh"

module btht_merge #(
    parameter int BUTTONS   = btht_pkg::BUTTONS_DEF,
    parameter int TIME_BITS = btht_pkg::TIME_BITS_DEF
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    input  wire btht_pkg::lane_cmd_t                   cmd,
    input  wire btht_pkg::lane_stat_t [BUTTONS-1:0]    stat,
    input  wire logic [BUTTONS-1:0][TIME_BITS-1:0]     since,
    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output logic [btht_pkg::M_DATA_BITS-1:0]           out_data
);

    localparam int VIS = (BUTTONS < btht_pkg::MASK_BITS) ? BUTTONS : btht_pkg::MASK_BITS;

    logic link_reg, link_next;
    logic in_fire;

    logic [btht_pkg::MASK_BITS-1:0] down_m, down_any_m, tap_m, hold_m, proc_m;
    logic [TIME_BITS-1:0]           since_or;
    logic [btht_pkg::WIDE_BITS-1:0] since_wide;
    logic [btht_pkg::M_DATA_BITS-1:0] result;

    logic                             main_valid_reg, main_valid_next;
    logic [btht_pkg::M_DATA_BITS-1:0] main_data_reg, main_data_next;
    logic                             skid_valid_reg, skid_valid_next;
    logic [btht_pkg::M_DATA_BITS-1:0] skid_data_reg, skid_data_next;

    assign in_ready = ~skid_valid_reg;
    assign in_fire  = in_valid & in_ready;

    assign link_next = (in_fire && cmd.action == btht_pkg::ACT_POLL) ? cmd.connected : link_reg;

    genvar gi;
    generate
        for (gi = 0; gi < btht_pkg::MASK_BITS; gi++) begin : g_mask
            if (gi < VIS) begin : g_live
                assign down_m[gi]     = stat[gi].down;
                assign down_any_m[gi] = stat[gi].down_any;
                assign tap_m[gi]      = stat[gi].tap;
                assign hold_m[gi]     = stat[gi].hold;
                assign proc_m[gi]     = stat[gi].processed;
            end else begin : g_none
                assign down_m[gi]     = 1'b0;
                assign down_any_m[gi] = 1'b0;
                assign tap_m[gi]      = 1'b0;
                assign hold_m[gi]     = 1'b0;
                assign proc_m[gi]     = 1'b0;
            end
        end
    endgenerate

    // at most one lane is selected, so an OR picks its press time
    always_comb begin
        since_or = '0;
        for (int i = 0; i < BUTTONS; i++) begin
            since_or = since_or | since[i];
        end
    end

    assign since_wide = btht_pkg::WIDE_BITS'(since_or);

    assign result = {7'd0, since_wide[btht_pkg::SINCE_BITS-1:0], proc_m, hold_m, tap_m,
                     down_any_m, down_m, link_next};

    always_comb begin
        main_valid_next = main_valid_reg;
        main_data_next  = main_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (main_valid_reg && out_ready) begin
            if (skid_valid_reg) begin
                main_data_next  = skid_data_reg;
                skid_valid_next = 1'b0;
            end else begin
                main_valid_next = 1'b0;
            end
        end
        if (in_fire) begin
            if (!main_valid_next) begin
                main_valid_next = 1'b1;
                main_data_next  = result;
            end else begin
                skid_valid_next = 1'b1;
                skid_data_next  = result;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            link_reg       <= 1'b0;
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            link_reg       <= link_next;
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        main_data_reg <= main_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign out_valid = main_valid_reg;
    assign out_data  = main_data_reg;

    `BTHT_ASSERT_IMP(a_skid_behind_main, aclk, aresetn, skid_valid_reg, main_valid_reg)
    `BTHT_ASSERT_NXT(a_fire_gives_result, aclk, aresetn, in_fire, main_valid_reg)
    `BTHT_ASSERT_NXT(a_skid_refills_main, aclk, aresetn,
                     skid_valid_reg && out_ready, main_valid_reg && !skid_valid_reg)
    `BTHT_ASSERT_NXT(a_stall_fills_skid, aclk, aresetn,
                     in_fire && main_valid_reg && !out_ready, skid_valid_reg)

endmodule

`default_nettype wire

>>> rtl/button_tap_hold_tracker.sv
// Button tap/hold tracker top level: lanes per button plus result merge.
//
// Input stream (s_axis_*): one word per poll or command. tuser carries the action
// (poll, ignore all held, mark processed, query button); tdata carries the tick,
// the connected flag, the held mask and the button index.
// Output stream (m_axis_*): exactly one result word per input word, in order,
// holding link state, the five button masks and the queried press time.
// Config: cfg_wr_en/cfg_wr_data write the hold threshold in ticks; write it only
// while no words are in flight.
// Each button has its own lane doing one wrapped subtract and one compare, so a
// word is accepted every cycle while s_axis_tready is high.
// Results sit in an output register backed by a skid register: s_axis_tready only
// drops once both hold words, so one stalled result never blocks the next input.
// Reset (aresetn low, synchronous) clears all button state, the link flag and both
// output slots, and sets the threshold to 500 ticks. No clearing pass is needed.
`default_nettype none

module button_tap_hold_tracker #(
    parameter int BUTTONS   = btht_pkg::BUTTONS_DEF,
    parameter int TIME_BITS = btht_pkg::TIME_BITS_DEF
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 cfg_wr_en,
    input  wire logic [btht_pkg::THR_BITS-1:0]        cfg_wr_data,   // hold_threshold
    input  wire logic                                 s_axis_tvalid,
    output logic                                      s_axis_tready,
    // now[31:0], connected[32], held_mask[48:33], button[52:49], zero pad
    input  wire logic [btht_pkg::S_DATA_BITS-1:0]     s_axis_tdata,
    // action[1:0]
    input  wire logic [btht_pkg::ACT_BITS-1:0]        s_axis_tuser,
    output logic                                      m_axis_tvalid,
    input  wire logic                                 m_axis_tready,
    // link_up[0], down_mask[16:1], down_any_mask[32:17], tap_mask[48:33],
    // hold_mask[64:49], processed_mask[80:65], down_since[112:81], zero pad
    output logic [btht_pkg::M_DATA_BITS-1:0]          m_axis_tdata
);

    logic [btht_pkg::THR_BITS-1:0]  threshold_reg;
    btht_pkg::lane_cmd_t            cmd;
    logic [btht_pkg::NOW_BITS-1:0]  now_in;
    logic [btht_pkg::WIDE_BITS-1:0] now_wide;
    logic [TIME_BITS-1:0]           now_t;
    logic [btht_pkg::MASK_BITS-1:0] held_in;
    logic                           in_fire;

    btht_pkg::lane_stat_t [BUTTONS-1:0]  stat;
    logic [BUTTONS-1:0][TIME_BITS-1:0]   since;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg <= btht_pkg::THR_RESET;
        end else if (cfg_wr_en) begin
            threshold_reg <= cfg_wr_data;
        end
    end

    assign now_in        = s_axis_tdata[31:0];
    assign held_in       = s_axis_tdata[48:33];
    assign cmd.action    = btht_pkg::action_t'(s_axis_tuser);
    assign cmd.connected = s_axis_tdata[32];
    assign cmd.button    = s_axis_tdata[52:49];

    assign now_wide = btht_pkg::WIDE_BITS'(now_in);
    assign now_t    = now_wide[TIME_BITS-1:0];

    assign in_fire = s_axis_tvalid & s_axis_tready;

    genvar gi;
    generate
        for (gi = 0; gi < BUTTONS; gi++) begin : g_lane
            logic held_b;
            logic sel_b;
            if (gi < btht_pkg::MASK_BITS) begin : g_addr
                assign held_b = held_in[gi];
                assign sel_b  = (cmd.button == btht_pkg::BTN_BITS'(gi));
            end else begin : g_hidden
                assign held_b = 1'b0;
                assign sel_b  = 1'b0;
            end

            btht_lane #(
                .TIME_BITS (TIME_BITS)
            ) u_lane (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .in_fire   (in_fire),
                .cmd       (cmd),
                .now       (now_t),
                .held      (held_b),
                .sel       (sel_b),
                .threshold (threshold_reg),
                .stat      (stat[gi]),
                .since     (since[gi])
            );
        end
    endgenerate

    btht_merge #(
        .BUTTONS   (BUTTONS),
        .TIME_BITS (TIME_BITS)
    ) u_merge (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .cmd       (cmd),
        .stat      (stat),
        .since     (since),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

endmodule

`default_nettype wire

>>> tb/button_tap_hold_tracker_tb.sv
// Self-checking testbench for the button tap/hold tracker stream block.
`timescale 1ns / 100ps

module button_tap_hold_tracker_tb;

    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int HOLD_OFF_CYCLES = 80;
    localparam int PHASE_WORDS     = 180;

    // packed so that it lines up with m_axis_tdata[112:0], link flag in bit 0
    typedef struct packed {
        logic [31:0] since;
        logic [15:0] proc_marks;
        logic [15:0] hold;
        logic [15:0] tap;
        logic [15:0] down_any;
        logic [15:0] down;
        logic        link;
    } pad_status_t;

    logic                             aclk = 1'b0;
    logic                             aresetn = 1'b0;
    logic                             cfg_wr_en = 1'b0;
    logic [btht_pkg::THR_BITS-1:0]    cfg_wr_data = '0;
    logic                             s_axis_tvalid = 1'b0;
    logic                             s_axis_tready;
    logic [btht_pkg::S_DATA_BITS-1:0] s_axis_tdata = '0;
    logic [btht_pkg::ACT_BITS-1:0]    s_axis_tuser = '0;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready = 1'b0;
    logic [btht_pkg::M_DATA_BITS-1:0] m_axis_tdata;

    // pad state as the block should hold it
    logic [31:0]       start_tick [16];
    btht_pkg::kind_t   kind_of [16];
    logic [15:0] pressed_m = '0;
    logic [15:0] ignore_m = '0;
    logic [15:0] proc_m = '0;
    logic        link_m = 1'b0;
    logic [31:0] thr_m = btht_pkg::THR_RESET;

    pad_status_t status_due [$];
    int          mismatches = 0;
    int          idle_cycles = 0;
    bit          src_gaps = 1'b1;
    bit          sink_gaps = 1'b1;
    bit          hold_off_req = 1'b0;
    logic [31:0] tick_now = '0;
    logic [15:0] held_now = '0;

    button_tap_hold_tracker DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    initial begin
        for (int i = 0; i < 16; i++) begin
            start_tick[i] = '0;
            kind_of[i] = btht_pkg::KIND_NONE;
        end
    end

    function automatic pad_status_t apply_word(input btht_pkg::action_t act,
            input logic [31:0] now, input logic conn, input logic [15:0] held,
            input logic [3:0] btn);
        pad_status_t st;
        logic [31:0] elapsed;
        st = '0;
        case (act)
            btht_pkg::ACT_POLL: begin
                link_m = conn;
                proc_m = '0;
                for (int i = 0; i < 16; i++) begin
                    if (!conn) begin
                        kind_of[i] = btht_pkg::KIND_NONE;
                    end else if (!pressed_m[i]) begin
                        kind_of[i] = btht_pkg::KIND_NONE;
                        if (held[i]) begin
                            start_tick[i] = now;
                            pressed_m[i] = 1'b1;
                        end
                    end else if (!held[i]) begin
                        elapsed = now - start_tick[i];   // wraps mod 2^32
                        ignore_m[i] = 1'b0;
                        pressed_m[i] = 1'b0;
                        start_tick[i] = '0;
                        kind_of[i] = (elapsed >= thr_m) ? btht_pkg::KIND_HOLD
                                                        : btht_pkg::KIND_TAP;
                    end
                end
            end
            btht_pkg::ACT_IGNORE: ignore_m = ignore_m | pressed_m;
            btht_pkg::ACT_MARK:   proc_m[btn] = 1'b1;
            btht_pkg::ACT_QUERY: begin
                if (pressed_m[btn])
                    st.since = start_tick[btn];
            end
            default: begin
            end
        endcase
        st.link = link_m;
        st.down = pressed_m & ~ignore_m;
        st.down_any = pressed_m;
        st.proc_marks = proc_m;
        for (int i = 0; i < 16; i++) begin
            st.tap[i] = (kind_of[i] == btht_pkg::KIND_TAP);
            st.hold[i] = (kind_of[i] == btht_pkg::KIND_HOLD);
        end
        return st;
    endfunction

    // valid is left high after a handshake; the next word or wait_idle decides
    task automatic send_word(input btht_pkg::action_t act, input logic [31:0] now,
            input logic conn, input logic [15:0] held, input logic [3:0] btn);
        int gap;
        gap = src_gaps ? $urandom_range(0, 14) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {3'b000, btn, held, conn, now};
        s_axis_tuser <= act;
        do @(posedge aclk); while (!s_axis_tready);
        status_due.push_back(apply_word(act, now, conn, held, btn));
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (status_due.size() != 0) @(posedge aclk);
    endtask

    task automatic write_threshold(input logic [31:0] val);
        wait_idle();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        thr_m = val;
    endtask

    // mostly a coherent poll sequence with advancing ticks, some noise words
    task automatic send_random_word();
        int sel;
        int step_max;
        sel = $urandom_range(0, 99);
        step_max = (thr_m > 32'd3000) ? 3000 : int'(thr_m / 32'd3) + 2;
        if (sel < 8) begin
            send_word(btht_pkg::action_t'($urandom_range(0, 3)), $urandom, 1'($urandom),
                      16'($urandom), 4'($urandom));
        end else if (sel < 70) begin
            tick_now = tick_now + 32'($urandom_range(0, step_max));
            if ($urandom_range(0, 9) == 0)
                held_now = 16'($urandom);
            else
                held_now = held_now ^ 16'($urandom & $urandom & $urandom);
            send_word(btht_pkg::ACT_POLL, tick_now, $urandom_range(0, 15) != 0, held_now,
                      4'($urandom));
        end else if (sel < 78) begin
            send_word(btht_pkg::ACT_IGNORE, $urandom, 1'($urandom), 16'($urandom),
                      4'($urandom));
        end else if (sel < 88) begin
            send_word(btht_pkg::ACT_MARK, $urandom, 1'($urandom), 16'($urandom),
                      4'($urandom));
        end else begin
            send_word(btht_pkg::ACT_QUERY, $urandom, 1'($urandom), 16'($urandom),
                      4'($urandom));
        end
    endtask

    task automatic test_reset_defaults();
        send_word(btht_pkg::ACT_QUERY, 32'd0, 1'b0, 16'h0000, 4'd0);
    endtask

    // default threshold 500: one tick short is a tap, exactly 500 is a hold
    task automatic test_tap_hold_split();
        send_word(btht_pkg::ACT_POLL, 32'd100, 1'b1, 16'hFFFF, 4'd0);
        send_word(btht_pkg::ACT_QUERY, 32'd0, 1'b0, 16'h0000, 4'd15);
        send_word(btht_pkg::ACT_POLL, 32'd599, 1'b1, 16'hFFFE, 4'd0);
        send_word(btht_pkg::ACT_POLL, 32'd600, 1'b1, 16'h0000, 4'd0);
        send_word(btht_pkg::ACT_POLL, 32'd0, 1'b1, 16'h0001, 4'd0);   // press at tick zero
        send_word(btht_pkg::ACT_QUERY, 32'hFFFF_FFFF, 1'b1, 16'hFFFF, 4'd0);
        send_word(btht_pkg::ACT_POLL, 32'hFFFF_FF00, 1'b1, 16'h0000, 4'd0);
        send_word(btht_pkg::ACT_POLL, 32'hFFFF_FF00, 1'b1, 16'h8000, 4'd0);
        send_word(btht_pkg::ACT_POLL, 32'h0000_00F4, 1'b1, 16'h0000, 4'd0); // wraps to 500
    endtask

    task automatic test_ignore_and_mark();
        send_word(btht_pkg::ACT_POLL, 32'd1000, 1'b1, 16'h00F0, 4'd0);
        send_word(btht_pkg::ACT_IGNORE, 32'd0, 1'b0, 16'h0000, 4'd0);
        send_word(btht_pkg::ACT_POLL, 32'd1010, 1'b1, 16'h01F0, 4'd0);
        send_word(btht_pkg::ACT_MARK, 32'd0, 1'b0, 16'h0000, 4'd3);
        send_word(btht_pkg::ACT_MARK, 32'd0, 1'b0, 16'h0000, 4'd15);
        send_word(btht_pkg::ACT_QUERY, 32'd0, 1'b0, 16'h0000, 4'd4);  // ignored, still down
        send_word(btht_pkg::ACT_POLL, 32'd1020, 1'b1, 16'h0100, 4'd0);
    endtask

    task automatic test_disconnect();
        send_word(btht_pkg::ACT_POLL, 32'd2000, 1'b0, 16'hFFFF, 4'd0);
        send_word(btht_pkg::ACT_QUERY, 32'd0, 1'b0, 16'h0000, 4'd8);
        send_word(btht_pkg::ACT_POLL, 32'd3000, 1'b1, 16'h0000, 4'd0);
    endtask

    task automatic test_threshold_extremes();
        write_threshold(32'd1);
        send_word(btht_pkg::ACT_POLL, 32'd5, 1'b1, 16'h0003, 4'd0);
        send_word(btht_pkg::ACT_POLL, 32'd5, 1'b1, 16'h0001, 4'd0);
        send_word(btht_pkg::ACT_POLL, 32'd6, 1'b1, 16'h0000, 4'd0);
        write_threshold(32'd0);                                 // any release is a hold
        send_word(btht_pkg::ACT_POLL, 32'd7, 1'b1, 16'h0001, 4'd0);
        send_word(btht_pkg::ACT_POLL, 32'd7, 1'b1, 16'h0000, 4'd0);
        write_threshold(32'hFFFF_FFFF);
        send_word(btht_pkg::ACT_POLL, 32'd10, 1'b1, 16'h0003, 4'd0);
        send_word(btht_pkg::ACT_POLL, 32'd9, 1'b1, 16'h0002, 4'd0);
        send_word(btht_pkg::ACT_POLL, 32'd20, 1'b1, 16'h0000, 4'd0);
    endtask

    // result side stalls long while words keep coming, so the input must back up
    task automatic test_backpressure();
        write_threshold(32'd64);
        src_gaps = 1'b0;
        hold_off_req = 1'b1;
        repeat (40) send_random_word();
        wait_idle();
        src_gaps = 1'b1;
    endtask

    task automatic test_random_traffic();
        logic [31:0] levels [6];
        levels = '{32'd1, 32'd40, 32'd500, 32'hFFFF_FFFF, 32'd0, 32'd300};
        levels[5] = 32'($urandom_range(2, 400));
        for (int ph = 0; ph < 6; ph++) begin
            write_threshold(levels[ph]);
            src_gaps = (ph % 3) != 1 && ph != 5;
            sink_gaps = (ph % 3) != 2 && ph != 5;
            repeat (PHASE_WORDS) send_random_word();
        end
        write_threshold(btht_pkg::THR_RESET);
        src_gaps = 1'b1;
        sink_gaps = 1'b1;
        repeat (40) send_random_word();
    endtask

    initial begin : result_sink
        int stall;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (hold_off_req) begin
                m_axis_tready <= 1'b0;
                for (int n = 0; n < HOLD_OFF_CYCLES; n++) @(posedge aclk);
                hold_off_req = 1'b0;
            end
            stall = sink_gaps ? $urandom_range(0, 14) : 0;
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge aclk); while (!m_axis_tvalid);
        end
    end

    function automatic void check_field(input string label, input logic [31:0] want,
            input logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= 100)
                $display("%0t ns: %s mismatch, expected %h, actual %h",
                         $time, label, want, got);
        end
    endfunction

    always @(posedge aclk) begin : result_check
        pad_status_t want;
        pad_status_t got;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[112:0];
            if (status_due.size() == 0) begin
                mismatches++;
                $display("%0t ns: unexpected result word, expected none, actual %h",
                         $time, m_axis_tdata);
            end else begin
                want = status_due.pop_front();
                check_field("link_up", 32'(want.link), 32'(got.link));
                check_field("down_mask", 32'(want.down), 32'(got.down));
                check_field("down_any_mask", 32'(want.down_any), 32'(got.down_any));
                check_field("tap_mask", 32'(want.tap), 32'(got.tap));
                check_field("hold_mask", 32'(want.hold), 32'(got.hold));
                check_field("processed_mask", 32'(want.proc_marks), 32'(got.proc_marks));
                check_field("down_since", want.since, got.since);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t ns: no word moved for %0d cycles", $time, idle_cycles);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_defaults();
        test_tap_hold_split();
        test_ignore_and_mark();
        test_disconnect();
        test_threshold_extremes();
        test_backpressure();
        test_random_traffic();
        wait_idle();
        repeat (8) @(posedge aclk);
        if (mismatches == 0 && status_due.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
